/* rtl/core/bpk_pkg.sv */
// -----------------------------------------------------------------------------
// bpk_pkg: shared types and constants for the fixed-width bit packer
// Field sizes, queue entry layout, register codes and the field width function.
// -----------------------------------------------------------------------------
package bpk_pkg;

   localparam int VALUE_BITS_DEFAULT = 22;
   localparam int MAG_BITS           = 21;
   localparam int FIELD_BITS         = MAG_BITS + 1;
   localparam int WIDTH_BITS         = $clog2(FIELD_BITS + 1);
   localparam int BYTE_BITS          = 8;
   localparam int PEND_BITS          = BYTE_BITS - 1;
   localparam int ACC_BITS           = PEND_BITS + FIELD_BITS;
   localparam int CNT_BITS           = $clog2(ACC_BITS + 1);
   localparam int QUEUE_DEPTH        = 2;
   localparam int QUEUE_PTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [MAG_BITS-1:0] MAG_RESET = MAG_BITS'(1000);

   // register index, taken from paddr[2]
   localparam logic REG_MAX_MAGNITUDE = 1'b0;

   typedef struct packed {
      logic [FIELD_BITS-1:0] field;
      logic [WIDTH_BITS-1:0] width;
      logic                  eov;
   } bpk_entry_type;

   typedef struct packed {
      logic [QUEUE_COUNT_BITS-1:0] count;
      logic                        full;
      logic                        push;
      logic                        pop;
   } bpk_queue_status_type;

   // sign bit plus bit length of the magnitude; 1 for zero
   function automatic logic [WIDTH_BITS-1:0] field_width(input logic [MAG_BITS-1:0] mag);
      logic [WIDTH_BITS-1:0] w;
      w = WIDTH_BITS'(1);
      for (int i = 0; i < MAG_BITS; i++) begin
         if (mag[i]) begin
            w = WIDTH_BITS'(i + 2);
         end
      end
      return w;
   endfunction

endpackage

/* rtl/core/bpk_if.sv */
// -----------------------------------------------------------------------------
// bpk_if: request and response channel interfaces
// Valid/ready channels carrying the packer's request and output byte.
// -----------------------------------------------------------------------------
interface bpk_req_if #(
   parameter int VALUE_BITS = bpk_pkg::VALUE_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         end_of_vector;

   modport source (output valid, output value, output end_of_vector, input ready);
   modport sink   (input valid, input value, input end_of_vector, output ready);
endinterface

interface bpk_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpk_pkg::BYTE_BITS-1:0]  packed_byte;
   logic                           last_byte;

   modport source (output valid, output packed_byte, output last_byte, input ready);
   modport sink   (input valid, input packed_byte, input last_byte, output ready);
endinterface

/* rtl/core/bpk_front.sv */
// -----------------------------------------------------------------------------
// bpk_front: register port and request intake
// Holds max_magnitude and the derived field width; trims each request value
// to the field width and hands it to the queue.
// -----------------------------------------------------------------------------
module bpk_front #(
   parameter int VALUE_BITS = bpk_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   bpk_req_if.sink                            req_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bpk_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bpk_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bpk_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   input  logic                               queue_full,
   output logic                               push_valid,
   output bpk_pkg::bpk_entry_type             push_entry
);

   localparam int EXT_BITS = (VALUE_BITS > bpk_pkg::FIELD_BITS) ? VALUE_BITS
                                                                : bpk_pkg::FIELD_BITS;

   logic [bpk_pkg::MAG_BITS-1:0]   max_mag_ff;
   logic [bpk_pkg::WIDTH_BITS-1:0] width_ff;
   logic                           csr_write;
   logic signed [EXT_BITS-1:0]     value_ext;
   logic [bpk_pkg::FIELD_BITS-1:0] field_mask;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == bpk_pkg::REG_MAX_MAGNITUDE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bpk_pkg::REG_MAX_MAGNITUDE)
                       ? bpk_pkg::CSR_DATA_BITS'(max_mag_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_mag_ff <= bpk_pkg::MAG_RESET;
         width_ff   <= bpk_pkg::field_width(bpk_pkg::MAG_RESET);
      end else if (csr_write) begin
         max_mag_ff <= csr_pwdata[bpk_pkg::MAG_BITS-1:0];
         width_ff   <= bpk_pkg::field_width(csr_pwdata[bpk_pkg::MAG_BITS-1:0]);
      end
   end

   // sign-extend narrow values, then keep the low width bits
   assign value_ext  = EXT_BITS'(req_bus.value);
   assign field_mask = ~({bpk_pkg::FIELD_BITS{1'b1}} << width_ff);

   assign req_bus.ready    = !queue_full;
   assign push_valid       = req_bus.valid;
   assign push_entry.field = value_ext[bpk_pkg::FIELD_BITS-1:0] & field_mask;
   assign push_entry.width = width_ff;
   assign push_entry.eov   = req_bus.end_of_vector;

endmodule

/* rtl/core/bpk_queue.sv */
// -----------------------------------------------------------------------------
// bpk_queue: short request queue between intake and byte emitter
// -----------------------------------------------------------------------------
module bpk_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  bpk_pkg::bpk_entry_type        push_entry,
   input  logic                          pop,
   output bpk_pkg::bpk_entry_type        head_entry,
   output logic                          head_valid,
   output bpk_pkg::bpk_queue_status_type status
);

   bpk_pkg::bpk_entry_type                 mem_ff [bpk_pkg::QUEUE_DEPTH];
   logic [bpk_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff;
   logic [bpk_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff;
   logic [bpk_pkg::QUEUE_COUNT_BITS-1:0]   count_ff;
   logic                                   full;
   logic                                   push;
   logic                                   pop_fire;

   assign full     = (count_ff == bpk_pkg::QUEUE_COUNT_BITS'(bpk_pkg::QUEUE_DEPTH));
   assign push     = push_valid && !full;
   assign pop_fire = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_fire && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head_entry   = mem_ff[rd_ptr_ff];
   assign head_valid   = (count_ff != '0);
   assign status.count = count_ff;
   assign status.full  = full;
   assign status.push  = push;
   assign status.pop   = pop_fire;

endmodule

/* rtl/core/bpk_back.sv */
// -----------------------------------------------------------------------------
// bpk_back: bit accumulator and byte emitter
// Merges queued fields into pending bits, emits one byte per cycle while rsp
// ready holds, MSB first; pads and flags the final byte on end of vector.
// -----------------------------------------------------------------------------
module bpk_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bpk_pkg::bpk_entry_type  head_entry,
   input  logic                    head_valid,
   output logic                    pop,
   output logic                    busy,
   bpk_rsp_if.source               rsp_bus
);

   localparam int ACC  = bpk_pkg::ACC_BITS;
   localparam int CNT  = bpk_pkg::CNT_BITS;
   localparam int BYTE = bpk_pkg::BYTE_BITS;

   logic [ACC-1:0]  acc_ff,   acc_in;
   logic [CNT-1:0]  cnt_ff,   cnt_in;   // valid bits at the bottom of acc
   logic            eov_ff,   eov_in;
   logic            valid_ff, valid_in;
   logic [BYTE-1:0] byte_ff,  byte_in;
   logic            last_ff,  last_in;

   logic            has_bytes;
   logic            has_flush;
   logic            slot_free;
   logic            step;
   logic            done;
   logic [CNT-1:0]  rem;
   logic [CNT-1:0]  base_cnt;
   logic [ACC-1:0]  shifted;
   logic [BYTE-1:0] tail_bits;
   logic [BYTE-1:0] byte_val;

   always_comb begin
      has_bytes = (cnt_ff >= CNT'(BYTE));
      has_flush = eov_ff && (cnt_ff != '0);
      busy      = has_bytes || has_flush;
      slot_free = !valid_ff || rsp_bus.ready;
      step      = busy && slot_free;
      rem       = has_bytes ? (cnt_ff - CNT'(BYTE)) : '0;
      shifted   = acc_ff >> rem;
      tail_bits = acc_ff[BYTE-1:0];
      // flush pads the remaining bits with zeros below them
      byte_val  = has_bytes ? shifted[BYTE-1:0]
                            : (tail_bits << (CNT'(BYTE) - cnt_ff));
      done      = (rem < CNT'(BYTE)) && !(eov_ff && (rem != '0));
      pop       = head_valid && (!busy || (step && done));
      base_cnt  = busy ? rem : cnt_ff;
   end

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      eov_in   = eov_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (pop) begin
         acc_in = (acc_ff << head_entry.width) | ACC'(head_entry.field);
         cnt_in = base_cnt + CNT'(head_entry.width);
         eov_in = head_entry.eov;
      end else if (step) begin
         cnt_in = rem;
         eov_in = done ? 1'b0 : eov_ff;
      end
      if (step) begin
         valid_in = 1'b1;
         byte_in  = byte_val;
         last_in  = eov_ff && (rem == '0);
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (reset) begin
         cnt_ff   <= '0;
         eov_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         eov_ff   <= eov_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.packed_byte = byte_ff;
   assign rsp_bus.last_byte   = last_ff;

endmodule

/* rtl/core/fixed_width_bit_packer.sv */
// -----------------------------------------------------------------------------
// fixed_width_bit_packer: MSB-first packer of signed fixed-width fields
// Each request value is trimmed to 1 + bitlen(max_magnitude) bits and
// appended to a bit stream that leaves as bytes, first bit in bit 7.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-----------------------------------
//   req_bus   | in  | valid/ready        | value (signed), end_of_vector
//   rsp_bus   | out | valid/ready        | packed_byte, last_byte
//   csr_*     | in  | APB write, pready=1| max_magnitude at byte address 0
//
// Flow: one byte leaves per cycle while rsp ready holds; fields of 8 bits
//   or less are taken at one per cycle, but an end-of-vector flush holds
//   intake for its padded byte; wider fields load the next request as their
//   last byte leaves. A request passes queue entry, field load, byte register.
// Reset: synchronous, active high; clears the queue, pending bits and
//   output valid, and loads max_magnitude = 1000 (field width 11).
// Stalls: the 2-entry queue decouples intake from the emitter. While the
//   output register waits on rsp ready the emitter holds its bytes but still
//   loads a queued field when fewer than 8 bits are pending and no flush waits.
// -----------------------------------------------------------------------------
module fixed_width_bit_packer #(
   parameter int VALUE_BITS = bpk_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   bpk_req_if.sink                            req_bus,
   bpk_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bpk_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [bpk_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [bpk_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic                          push_valid;
   bpk_pkg::bpk_entry_type        push_entry;
   bpk_pkg::bpk_entry_type        head_entry;
   logic                          head_valid;
   logic                          pop;
   logic                          back_busy;
   bpk_pkg::bpk_queue_status_type q_status;

   // front: register port, request intake, field trimming
   bpk_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .queue_full  (q_status.full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   // queue: trimmed fields with their width and end-of-vector mark
   bpk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .status     (q_status)
   );

   // back: accumulator and byte emitter; loads the next field in the same
   // cycle its last byte goes out, so the emitter does not idle between fields
   bpk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .busy       (back_busy),
      .rsp_bus    (rsp_bus)
   );

   // emitter never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      pop && !head_valid |-> !q_status.pop)
      else $error("pop taken from empty queue");

   // idle emitter always takes a waiting request
   assert property (@(posedge clock) disable iff (reset)
      (q_status.count != '0) && !back_busy |-> q_status.pop)
      else $error("emitter idle with request waiting");

   // queue occupancy tracks push and pop
   assert property (@(posedge clock) disable iff (reset)
      q_status.push && !q_status.pop |=> q_status.count == $past(q_status.count) + 1'b1)
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      q_status.pop && !q_status.push |=> q_status.count == $past(q_status.count) - 1'b1)
      else $error("queue count missed a pop");

endmodule
